/* src/pfde_pkg.sv */
`timescale 1ns / 1ps

package pfde_pkg;

    localparam int DEF_SCREEN_WIDTH  = 256;
    localparam int DEF_SCREEN_HEIGHT = 64;

    // sized for the largest screen the block supports
    localparam int ADDR_W      = 15;
    localparam int PAGE_W      = 5;
    localparam int ROW_W       = PAGE_W + 4;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [2:0] MODE_PIXEL = 3'd0;
    localparam logic [2:0] MODE_HSPAN = 3'd1;
    localparam logic [2:0] MODE_VSPAN = 3'd2;
    localparam logic [2:0] MODE_FILL  = 3'd3;
    localparam logic [2:0] MODE_READ  = 3'd4;

    localparam logic [1:0] INK_CLEAR  = 2'd0;
    localparam logic [1:0] INK_SET    = 2'd1;
    localparam logic [1:0] INK_FLIP   = 2'd2;
    localparam logic [1:0] COLOR_NONE = 2'd3;

    typedef enum logic [1:0] {
        OP_ROW,
        OP_COL,
        OP_FILL,
        OP_READ
    } op_kind_t;

    typedef struct packed {
        op_kind_t          kind;
        logic [ADDR_W-1:0] addr;
        logic [ADDR_W-1:0] last;
        logic [1:0]        color;
        logic [7:0]        mask;
        logic [PAGE_W-1:0] page;
        logic [ROW_W-1:0]  row_lo;
        logic [ROW_W-1:0]  row_hi;
        logic              zero;
    } pfde_op_t;

    typedef struct packed {
        logic clearing;
        logic read_capture;
    } pfde_status_t;

endpackage

/* src/pfde_cmd_if.sv */
`timescale 1ns / 1ps

interface pfde_cmd_if;
    logic               valid;
    logic               ready;
    logic        [2:0]  mode;
    logic signed [15:0] x_pos;
    logic signed [15:0] y_pos;
    logic signed [15:0] span_end;
    logic        [1:0]  color;
    logic        [10:0] read_index;

    modport source (
        output valid,
        output mode,
        output x_pos,
        output y_pos,
        output span_end,
        output color,
        output read_index,
        input  ready
    );

    modport sink (
        input  valid,
        input  mode,
        input  x_pos,
        input  y_pos,
        input  span_end,
        input  color,
        input  read_index,
        output ready
    );
endinterface

/* src/pfde_rsp_if.sv */
`timescale 1ns / 1ps

interface pfde_rsp_if;
    logic       valid;
    logic       ready;
    logic [7:0] read_byte;

    modport source (
        output valid,
        output read_byte,
        input  ready
    );

    modport sink (
        input  valid,
        input  read_byte,
        output ready
    );
endinterface

/* src/pfde_front.sv */
`timescale 1ns / 1ps

module pfde_front #(
    parameter int SCREEN_WIDTH  = pfde_pkg::DEF_SCREEN_WIDTH,
    parameter int SCREEN_HEIGHT = pfde_pkg::DEF_SCREEN_HEIGHT
) (
    pfde_cmd_if.sink              cmd,
    input  pfde_pkg::pfde_status_t status,
    input  logic                  q_full,
    output logic                  push,
    output pfde_pkg::pfde_op_t    op
);
    import pfde_pkg::*;

    localparam int PAGE_COUNT = (SCREEN_HEIGHT + 7) / 8;
    localparam int FB_BYTES   = PAGE_COUNT * SCREEN_WIDTH;
    localparam logic signed [16:0] W_S = 17'(SCREEN_WIDTH);
    localparam logic signed [16:0] H_S = 17'(SCREEN_HEIGHT);
    localparam logic [ADDR_W-1:0] W_A    = ADDR_W'(SCREEN_WIDTH);
    localparam logic [ADDR_W-1:0] LAST_A = ADDR_W'(FB_BYTES - 1);

    logic signed [16:0] xs;
    logic signed [16:0] ys;
    logic signed [16:0] es;
    logic signed [16:0] hs;
    logic signed [16:0] he;
    logic signed [16:0] vs;
    logic signed [16:0] ve;
    logic signed [16:0] ve_m1;
    logic signed [16:0] span_m1;
    logic signed [16:0] col_sel;
    logic               is_pixel;
    logic               row_like;
    logic               draw_ok;
    logic               h_ok;
    logic               v_ok;
    logic               keep;
    logic [PAGE_W-1:0]  h_page;
    logic [PAGE_W-1:0]  v_first;
    logic [PAGE_W-1:0]  v_last;
    logic [PAGE_W-1:0]  page_sel;
    logic [ADDR_W-1:0]  base;
    pfde_op_t           op_c;

    always_comb
    begin
        xs       = {cmd.x_pos[15], cmd.x_pos};
        ys       = {cmd.y_pos[15], cmd.y_pos};
        es       = {cmd.span_end[15], cmd.span_end};
        is_pixel = (cmd.mode == MODE_PIXEL);
        row_like = is_pixel || (cmd.mode == MODE_HSPAN);
        draw_ok  = (cmd.color != COLOR_NONE);

        // horizontal clip, a pixel is a one-column span
        hs = (xs < 0) ? '0 : xs;
        he = (es > W_S) ? W_S : es;
        if (is_pixel)
        begin
            hs = xs;
            he = xs + 17'sd1;
        end
        h_ok = (ys >= 0) && (ys < H_S)
            && (is_pixel ? ((xs >= 0) && (xs < W_S)) : (hs < he));
        span_m1 = he - hs - 17'sd1;

        // vertical clip
        vs    = (ys < 0) ? '0 : ys;
        ve    = (es > H_S) ? H_S : es;
        v_ok  = (xs >= 0) && (xs < W_S) && (vs < ve);
        ve_m1 = ve - 17'sd1;

        h_page  = ys[PAGE_W+2:3];
        v_first = vs[PAGE_W+2:3];
        v_last  = ve_m1[PAGE_W+2:3];

        // columns are mirrored in the store
        page_sel = row_like ? h_page : v_first;
        col_sel  = row_like ? (W_S - he) : (W_S - 17'sd1 - xs);
        base     = ADDR_W'(page_sel) * W_A + col_sel[ADDR_W-1:0];

        op_c       = '0;
        op_c.color = cmd.color;
        op_c.addr  = base;
        keep       = 1'b0;
        unique case (cmd.mode)
            MODE_PIXEL, MODE_HSPAN:
            begin
                op_c.kind = OP_ROW;
                op_c.last = span_m1[ADDR_W-1:0];
                op_c.mask = 8'b1 << ys[2:0];
                keep      = h_ok && draw_ok;
            end
            MODE_VSPAN:
            begin
                op_c.kind   = OP_COL;
                op_c.last   = ADDR_W'(v_last - v_first);
                op_c.page   = v_first;
                op_c.row_lo = vs[ROW_W-1:0];
                op_c.row_hi = ve[ROW_W-1:0];
                keep        = v_ok && draw_ok;
            end
            MODE_FILL:
            begin
                op_c.kind = OP_FILL;
                op_c.addr = '0;
                op_c.last = LAST_A;
                op_c.mask = 8'hFF;
                keep      = draw_ok;
            end
            MODE_READ:
            begin
                op_c.kind = OP_READ;
                op_c.addr = ADDR_W'(cmd.read_index);
                op_c.zero = (32'(cmd.read_index) >= 32'(FB_BYTES));
                keep      = 1'b1;
            end
            default:
            begin
                keep = 1'b0;
            end
        endcase
    end

    assign cmd.ready = !status.clearing && !q_full;
    assign push      = cmd.valid && cmd.ready && keep;
    assign op        = op_c;

endmodule

/* src/pfde_queue.sv */
`timescale 1ns / 1ps

module pfde_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  pfde_pkg::pfde_op_t wr_op,
    input  logic               pop,
    output pfde_pkg::pfde_op_t rd_op,
    output logic               full,
    output logic               empty
);
    import pfde_pkg::*;

    localparam int QAW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam logic [QAW-1:0] PTR_LAST = QAW'(QUEUE_DEPTH - 1);
    localparam logic [QAW:0]   CNT_FULL = (QAW + 1)'(QUEUE_DEPTH);

    pfde_op_t       slot_reg [QUEUE_DEPTH];
    logic [QAW-1:0] wp_reg;
    logic [QAW-1:0] wp_next;
    logic [QAW-1:0] rp_reg;
    logic [QAW-1:0] rp_next;
    logic [QAW:0]   cnt_reg;
    logic [QAW:0]   cnt_next;

    always_comb
    begin
        wp_next  = wp_reg;
        rp_next  = rp_reg;
        cnt_next = cnt_reg;
        if (push)
        begin
            wp_next = (wp_reg == PTR_LAST) ? '0 : wp_reg + 1'b1;
        end
        if (pop)
        begin
            rp_next = (rp_reg == PTR_LAST) ? '0 : rp_reg + 1'b1;
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wp_reg] <= wr_op;
        end
    end

    assign rd_op = slot_reg[rp_reg];
    assign full  = (cnt_reg == CNT_FULL);
    assign empty = (cnt_reg == '0);

endmodule

/* src/pfde_back.sv */
`timescale 1ns / 1ps

module pfde_back #(
    parameter int SCREEN_WIDTH  = pfde_pkg::DEF_SCREEN_WIDTH,
    parameter int SCREEN_HEIGHT = pfde_pkg::DEF_SCREEN_HEIGHT
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  pfde_pkg::pfde_op_t     q_op,
    input  logic                   q_empty,
    output logic                   q_pop,
    pfde_rsp_if.source             rsp,
    output pfde_pkg::pfde_status_t status
);
    import pfde_pkg::*;

    localparam int PAGE_COUNT = (SCREEN_HEIGHT + 7) / 8;
    localparam int FB_BYTES   = PAGE_COUNT * SCREEN_WIDTH;
    localparam int AW         = $clog2(FB_BYTES);
    localparam logic [AW-1:0] W_AW    = AW'(SCREEN_WIDTH);
    localparam logic [AW-1:0] LAST_AW = AW'(FB_BYTES - 1);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_ISSUE,
        S_WRITE,
        S_RISSUE,
        S_RCAP
    } state_t;

    state_t            state_reg;
    state_t            state_next;
    logic [AW-1:0]     addr_reg;
    logic [AW-1:0]     addr_next;
    logic [AW-1:0]     cnt_reg;
    logic [AW-1:0]     cnt_next;
    logic [PAGE_W-1:0] pg_reg;
    logic [PAGE_W-1:0] pg_next;
    logic [ROW_W-1:0]  row_lo_reg;
    logic [ROW_W-1:0]  row_lo_next;
    logic [ROW_W-1:0]  row_hi_reg;
    logic [ROW_W-1:0]  row_hi_next;
    logic [7:0]        mask_reg;
    logic [7:0]        mask_next;
    logic [1:0]        color_reg;
    logic [1:0]        color_next;
    op_kind_t          kind_reg;
    op_kind_t          kind_next;
    logic              zero_reg;
    logic              zero_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [7:0]        out_byte_reg;
    logic [7:0]        out_byte_next;

    logic [7:0]        mem [FB_BYTES];
    logic [7:0]        rd_data_reg;
    logic              wr_en;
    logic [7:0]        wr_data;
    logic [7:0]        step_mask;
    logic [ROW_W-1:0]  row_n;

    function automatic logic [7:0] paint(
        input logic [7:0] d,
        input logic [7:0] m,
        input logic [1:0] c
    );
        logic [7:0] r;
        unique case (c)
            INK_CLEAR: r = d & ~m;
            INK_SET:   r = d | m;
            INK_FLIP:  r = d ^ m;
            default:   r = d;
        endcase
        return r;
    endfunction

    // per-page mask of the rows of a vertical span
    always_comb
    begin
        step_mask = mask_reg;
        row_n     = '0;
        if (kind_reg == OP_COL)
        begin
            for (int n = 0; n < 8; n++)
            begin
                row_n        = {1'b0, pg_reg, 3'(n)};
                step_mask[n] = (row_n >= row_lo_reg) && (row_n < row_hi_reg);
            end
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        addr_next      = addr_reg;
        cnt_next       = cnt_reg;
        pg_next        = pg_reg;
        row_lo_next    = row_lo_reg;
        row_hi_next    = row_hi_reg;
        mask_next      = mask_reg;
        color_next     = color_reg;
        kind_next      = kind_reg;
        zero_next      = zero_reg;
        out_valid_next = out_valid_reg;
        out_byte_next  = out_byte_reg;
        q_pop          = 1'b0;
        wr_en          = 1'b0;
        wr_data        = paint(rd_data_reg, step_mask, color_reg);

        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_CLEAR:
            begin
                wr_en     = 1'b1;
                wr_data   = '0;
                addr_next = addr_reg + 1'b1;
                if (addr_reg == LAST_AW)
                begin
                    addr_next  = '0;
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop       = 1'b1;
                    addr_next   = q_op.addr[AW-1:0];
                    cnt_next    = q_op.last[AW-1:0];
                    pg_next     = q_op.page;
                    row_lo_next = q_op.row_lo;
                    row_hi_next = q_op.row_hi;
                    mask_next   = q_op.mask;
                    color_next  = q_op.color;
                    kind_next   = q_op.kind;
                    zero_next   = q_op.zero;
                    state_next  = (q_op.kind == OP_READ) ? S_RISSUE : S_ISSUE;
                end
            end
            S_ISSUE:
            begin
                state_next = S_WRITE;
            end
            S_WRITE:
            begin
                wr_en = 1'b1;
                if (cnt_reg == '0)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    addr_next  = addr_reg + ((kind_reg == OP_COL) ? W_AW : AW'(1));
                    cnt_next   = cnt_reg - 1'b1;
                    pg_next    = pg_reg + 1'b1;
                    state_next = S_ISSUE;
                end
            end
            S_RISSUE:
            begin
                if (!out_valid_reg)
                begin
                    state_next = S_RCAP;
                end
            end
            S_RCAP:
            begin
                out_valid_next = 1'b1;
                out_byte_next  = zero_reg ? 8'h00 : rd_data_reg;
                state_next     = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            addr_reg      <= '0;
            cnt_reg       <= '0;
            pg_reg        <= '0;
            kind_reg      <= OP_ROW;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            addr_reg      <= addr_next;
            cnt_reg       <= cnt_next;
            pg_reg        <= pg_next;
            kind_reg      <= kind_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        row_lo_reg   <= row_lo_next;
        row_hi_reg   <= row_hi_next;
        mask_reg     <= mask_next;
        color_reg    <= color_next;
        zero_reg     <= zero_next;
        out_byte_reg <= out_byte_next;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[addr_reg] <= wr_data;
        end
        rd_data_reg <= mem[addr_reg];
    end

    assign rsp.valid           = out_valid_reg;
    assign rsp.read_byte       = out_byte_reg;
    assign status.clearing     = (state_reg == S_CLEAR);
    assign status.read_capture = (state_reg == S_RCAP);

endmodule

/* src/paged_framebuffer_draw_engine_unit.sv */
// a read word reaches rsp through the queue and the S_IDLE, S_RISSUE, S_RCAP states,
// S_RISSUE waiting on an unaccepted word; pixels, spans and fills go byte by byte
// via S_ISSUE and S_WRITE, a read-modify-write of the single-port framebuffer memory
// a two-entry command queue lets cmd keep accepting while the memory sequencer works
// reset: asynchronous, active low; afterwards a clearing pass zeroes the
// framebuffer, one byte a cycle (2048 bytes at default size), with cmd.ready low
`timescale 1ns / 1ps

module paged_framebuffer_draw_engine_unit #(
    parameter int SCREEN_WIDTH  = pfde_pkg::DEF_SCREEN_WIDTH,
    parameter int SCREEN_HEIGHT = pfde_pkg::DEF_SCREEN_HEIGHT
) (
    input  logic       clk,
    input  logic       rst_n,
    pfde_cmd_if.sink   cmd,
    pfde_rsp_if.source rsp
);
    import pfde_pkg::*;

    pfde_status_t status;
    pfde_op_t     push_op;
    pfde_op_t     head_op;
    logic         push;
    logic         q_pop;
    logic         q_full;
    logic         q_empty;

    pfde_front #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT)
    ) u_front (
        .cmd    (cmd),
        .status (status),
        .q_full (q_full),
        .push   (push),
        .op     (push_op)
    );

    pfde_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wr_op (push_op),
        .pop   (q_pop),
        .rd_op (head_op),
        .full  (q_full),
        .empty (q_empty)
    );

    pfde_back #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_op    (head_op),
        .q_empty (q_empty),
        .q_pop   (q_pop),
        .rsp     (rsp),
        .status  (status)
    );

    a_no_accept_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        status.clearing |-> !cmd.ready)
        else $error("command accepted during clearing pass");

    a_queue_empty_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        status.clearing |-> q_empty)
        else $error("queue holds work during clearing pass");

    a_word_from_read: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp.valid) |-> $past(status.read_capture))
        else $error("read word without a read capture");

endmodule

/* test/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
    import pfde_pkg::*;

    localparam int SW         = DEF_SCREEN_WIDTH;
    localparam int SH         = DEF_SCREEN_HEIGHT;
    localparam int FB_BYTES   = ((SH + 7) / 8) * SW;
    localparam int HOLD_LEN   = 400;
    localparam int IDLE_LIMIT = 40000;
    localparam int PHASE_LEN  = 400;
    localparam int SETTLE     = 50;

    localparam logic [2:0] MODE_SPARE_LO = 3'd5;
    localparam logic [2:0] MODE_SPARE_HI = 3'd7;

    typedef struct {
        logic        [2:0]  mode;
        logic signed [15:0] x_pos;
        logic signed [15:0] y_pos;
        logic signed [15:0] span_end;
        logic        [1:0]  color;
        logic        [10:0] read_index;
    } draw_cmd_t;

    typedef struct {
        logic [2:0] mode;
        int         x_pos;
        int         y_pos;
        int         span_end;
        logic [1:0] color;
        int         read_index;
        bit         typed;
        logic [7:0] byte_exp;
    } draw_row_t;

    localparam int ROWS = 27;

    draw_row_t draw_rows [0:ROWS-1] = '{
        '{MODE_READ,  0, 0, 0, INK_CLEAR, 0, 1'b1, 8'h00},
        '{MODE_READ,  0, 0, 0, INK_CLEAR, 2047, 1'b1, 8'h00},
        '{MODE_FILL,  0, 0, 0, INK_SET, 0, 1'b0, 8'h00},
        '{MODE_READ,  0, 0, 0, INK_CLEAR, 0, 1'b1, 8'hFF},
        '{MODE_READ,  0, 0, 0, INK_CLEAR, 2047, 1'b1, 8'hFF},
        '{MODE_FILL,  0, 0, 0, INK_FLIP, 0, 1'b0, 8'h00},
        '{MODE_READ,  0, 0, 0, INK_CLEAR, 1000, 1'b1, 8'h00},
        '{MODE_FILL,  0, 0, 0, COLOR_NONE, 0, 1'b0, 8'h00},
        '{MODE_READ,  0, 0, 0, INK_CLEAR, 5, 1'b1, 8'h00},
        '{MODE_PIXEL, 0, 0, 0, INK_SET, 0, 1'b0, 8'h00},
        '{MODE_READ,  0, 0, 0, INK_CLEAR, 255, 1'b1, 8'h01},
        '{MODE_PIXEL, 255, 63, 0, INK_SET, 0, 1'b0, 8'h00},
        '{MODE_READ,  0, 0, 0, INK_CLEAR, 1792, 1'b1, 8'h80},
        '{MODE_PIXEL, -32768, 32767, 0, INK_SET, 0, 1'b0, 8'h00},
        '{MODE_PIXEL, 256, 64, 0, INK_SET, 0, 1'b0, 8'h00},
        '{MODE_HSPAN, -32768, 8, 32767, INK_SET, 0, 1'b0, 8'h00},
        '{MODE_READ,  0, 0, 0, INK_CLEAR, 256, 1'b1, 8'h01},
        '{MODE_READ,  0, 0, 0, INK_CLEAR, 511, 1'b1, 8'h01},
        '{MODE_VSPAN, 0, -32768, 32767, INK_SET, 0, 1'b0, 8'h00},
        '{MODE_READ,  0, 0, 0, INK_CLEAR, 2047, 1'b1, 8'hFF},
        '{MODE_VSPAN, 0, 3, 5, INK_FLIP, 0, 1'b0, 8'h00},
        '{MODE_PIXEL, 0, 0, 0, INK_CLEAR, 0, 1'b0, 8'h00},
        '{MODE_READ,  0, 0, 0, INK_CLEAR, 255, 1'b1, 8'hE6},
        '{MODE_HSPAN, 10, 5, 10, INK_SET, 0, 1'b0, 8'h00},
        '{MODE_VSPAN, 255, -5, 2, COLOR_NONE, 0, 1'b0, 8'h00},
        '{MODE_SPARE_LO, 255, 0, 1, INK_SET, 0, 1'b0, 8'h00},
        '{MODE_READ,  0, 0, 0, INK_CLEAR, 0, 1'b1, 8'h00}
    };

    int idle_set  [4] = '{0, 68, 0, 25};
    int stall_set [4] = '{0, 0, 68, 25};

    logic clk;
    logic rst_n;

    pfde_cmd_if cmd ();
    pfde_rsp_if rsp ();

    paged_framebuffer_draw_engine_unit u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .rsp   (rsp)
    );

    logic [7:0] frame_copy [FB_BYTES];
    logic [7:0] read_back_q [$];
    int         recent_addr;
    int         fail_count;
    int         send_idle;
    int         recv_stall;
    bit         hold_req;
    bit         hold_done;
    int         hold_left;
    int         quiet_cycles;

    initial clk = 1'b0;
    always #5 clk = ~clk;

    function automatic void paint_byte(int idx, logic [7:0] bits, logic [1:0] color);
        if (idx < 0 || idx >= FB_BYTES)
            return;
        case (color)
            INK_CLEAR: frame_copy[idx] = frame_copy[idx] & ~bits;
            INK_SET:   frame_copy[idx] = frame_copy[idx] | bits;
            INK_FLIP:  frame_copy[idx] = frame_copy[idx] ^ bits;
            default: ;
        endcase
        recent_addr = idx;
    endfunction

    function automatic void plot(int x, int y, logic [1:0] color);
        if (x < 0 || x >= SW || y < 0 || y >= SH)
            return;
        paint_byte((y / 8) * SW + (SW - 1 - x), 8'(1 << (y % 8)), color);
    endfunction

    // returns 1 when the command produces a read word
    function automatic bit draw_frame(draw_cmd_t c, output logic [7:0] rd);
        int x;
        int y;
        int e;
        int lo;
        x  = int'(c.x_pos);
        y  = int'(c.y_pos);
        e  = int'(c.span_end);
        rd = 8'h00;
        case (c.mode)
            MODE_PIXEL: plot(x, y, c.color);
            MODE_HSPAN:
            begin
                if (y >= 0 && y < SH)
                begin
                    lo = (x < 0) ? 0 : x;
                    if (e > SW)
                        e = SW;
                    for (int i = lo; i < e; i++)
                        plot(i, y, c.color);
                end
            end
            MODE_VSPAN:
            begin
                if (x >= 0 && x < SW)
                begin
                    lo = (y < 0) ? 0 : y;
                    if (e > SH)
                        e = SH;
                    for (int i = lo; i < e; i++)
                        plot(x, i, c.color);
                end
            end
            MODE_FILL:
            begin
                for (int i = 0; i < FB_BYTES; i++)
                begin
                    case (c.color)
                        INK_CLEAR: frame_copy[i] = 8'h00;
                        INK_SET:   frame_copy[i] = 8'hFF;
                        INK_FLIP:  frame_copy[i] = frame_copy[i] ^ 8'hFF;
                        default: ;
                    endcase
                end
            end
            MODE_READ:
            begin
                rd = (int'(c.read_index) < FB_BYTES) ? frame_copy[c.read_index] : 8'h00;
                return 1'b1;
            end
            default: ;
        endcase
        return 1'b0;
    endfunction

    function automatic int rand_coord(int span);
        if ($urandom_range(99) < 10)
            return int'($signed(16'($urandom)));
        return int'($urandom_range(span + 16)) - 8;
    endfunction

    function automatic draw_cmd_t random_cmd();
        draw_cmd_t c;
        int pick;
        pick         = $urandom_range(999);
        c.x_pos      = 16'(rand_coord(SW));
        c.y_pos      = 16'(rand_coord(SH));
        c.span_end   = 16'($urandom);
        c.color      = ($urandom_range(19) == 0) ? COLOR_NONE : 2'($urandom_range(2));
        c.read_index = 11'($urandom);
        if (pick < 15)
            c.mode = MODE_FILL;
        else if (pick < 315)
            c.mode = MODE_PIXEL;
        else if (pick < 465)
        begin
            c.mode = MODE_HSPAN;
            if ($urandom_range(9) != 0)
                c.span_end = c.x_pos + 16'($urandom_range(52)) - 16'sd4;
        end
        else if (pick < 665)
        begin
            c.mode = MODE_VSPAN;
            if ($urandom_range(9) != 0)
                c.span_end = c.y_pos + 16'($urandom_range(24)) - 16'sd4;
        end
        else if (pick < 695)
            c.mode = 3'($urandom_range(MODE_SPARE_HI, MODE_SPARE_LO));
        else
        begin
            c.mode = MODE_READ;
            if ($urandom_range(99) < 60)
                c.read_index = 11'(recent_addr);
        end
        return c;
    endfunction

    task automatic send_word(draw_cmd_t c, bit typed, logic [7:0] byte_exp);
        logic [7:0] rd;
        while (send_idle > 0 && $urandom_range(99) < send_idle)
        begin
            cmd.valid <= 1'b0;
            @(posedge clk);
        end
        cmd.valid      <= 1'b1;
        cmd.mode       <= c.mode;
        cmd.x_pos      <= c.x_pos;
        cmd.y_pos      <= c.y_pos;
        cmd.span_end   <= c.span_end;
        cmd.color      <= c.color;
        cmd.read_index <= c.read_index;
        @(posedge clk);
        while (!cmd.ready)
            @(posedge clk);
        if (draw_frame(c, rd))
            read_back_q.push_back(typed ? byte_exp : rd);
    endtask

    task automatic wait_drained(int extra);
        cmd.valid <= 1'b0;
        while (read_back_q.size() != 0)
            @(posedge clk);
        repeat (extra) @(posedge clk);
    endtask

    // response check and receiver stall
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            rsp.ready <= 1'b0;
            hold_left <= 0;
            hold_done <= 1'b0;
        end
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                if (read_back_q.size() == 0)
                begin
                    $error("unexpected word: read_byte actual %02h", rsp.read_byte);
                    fail_count++;
                end
                else if (rsp.read_byte !== read_back_q[0])
                begin
                    $error("read_byte expected %02h actual %02h", read_back_q[0], rsp.read_byte);
                    fail_count++;
                    void'(read_back_q.pop_front());
                end
                else
                    void'(read_back_q.pop_front());
            end
            if (hold_req && !hold_done)
            begin
                hold_done <= 1'b1;
                hold_left <= HOLD_LEN;
                rsp.ready <= 1'b0;
            end
            else if (hold_left > 0)
            begin
                hold_left <= hold_left - 1;
                rsp.ready <= 1'b0;
            end
            else
                rsp.ready <= ($urandom_range(99) >= recv_stall);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (cmd.valid && cmd.ready) || (rsp.valid && rsp.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= IDLE_LIMIT)
        begin
            $display("tb_top failed");
            $finish;
        end
    end

    initial
    begin
        draw_cmd_t c;
        rst_n          = 1'b0;
        recent_addr    = 0;
        send_idle      = 0;
        recv_stall     = 0;
        hold_req       = 1'b0;
        cmd.valid      <= 1'b0;
        cmd.mode       <= MODE_PIXEL;
        cmd.x_pos      <= '0;
        cmd.y_pos      <= '0;
        cmd.span_end   <= '0;
        cmd.color      <= INK_CLEAR;
        cmd.read_index <= '0;
        for (int i = 0; i < FB_BYTES; i++)
            frame_copy[i] = 8'h00;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        for (int r = 0; r < ROWS; r++)
        begin
            c.mode       = draw_rows[r].mode;
            c.x_pos      = 16'(draw_rows[r].x_pos);
            c.y_pos      = 16'(draw_rows[r].y_pos);
            c.span_end   = 16'(draw_rows[r].span_end);
            c.color      = draw_rows[r].color;
            c.read_index = 11'(draw_rows[r].read_index);
            send_word(c, draw_rows[r].typed, draw_rows[r].byte_exp);
        end

        for (int p = 0; p < 4; p++)
        begin
            send_idle  = idle_set[p];
            recv_stall = stall_set[p];
            if (p == 0)
            begin
                // receiver holds off while reads pile up behind it
                hold_req = 1'b1;
                repeat (24)
                begin
                    c            = random_cmd();
                    c.mode       = MODE_READ;
                    c.read_index = 11'($urandom);
                    send_word(c, 1'b0, 8'h00);
                end
            end
            repeat (PHASE_LEN) send_word(random_cmd(), 1'b0, 8'h00);
            wait_drained(8);
        end

        wait_drained(SETTLE);
        if (fail_count == 0 && read_back_q.size() == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

endmodule

/* paged_framebuffer_draw_engine_unit.f */
src/pfde_pkg.sv
src/pfde_cmd_if.sv
src/pfde_rsp_if.sv
src/pfde_front.sv
src/pfde_queue.sv
src/pfde_back.sv
src/paged_framebuffer_draw_engine_unit.sv
test/tb_top.sv
